@@ rtl/spoc_pkg.sv @@
// ----------------------------------------------------------------------------
// spoc_pkg
// Shared types, constants and key ordering for the sorted pair counter.
// ----------------------------------------------------------------------------
package spoc_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        valid;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] cnt;
    } entry_t;

    typedef struct packed {
        logic add;
        logic hit;
        logic full;
        logic pop;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    // maps a float pattern to an unsigned key with the same order
    function automatic logic [31:0] order_key(input logic [31:0] bits);
        logic [31:0] mag;
        mag = {1'b0, bits[30:0]};
        if (bits[31])
        begin
            order_key = 32'h8000_0000 - mag;
        end
        else
        begin
            order_key = 32'h8000_0000 + mag;
        end
    endfunction

endpackage

@@ rtl/spoc_cell.sv @@
// ----------------------------------------------------------------------------
// spoc_cell
// One table slot: compares the incoming point, counts, inserts or shifts.
// ----------------------------------------------------------------------------
module spoc_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  spoc_pkg::cell_ctl_t ctl,
    input  logic [31:0]        pt_x,
    input  logic [31:0]        pt_y,
    input  logic               lt_prev,
    input  spoc_pkg::entry_t   left,
    input  spoc_pkg::entry_t   right,
    output logic               lt,
    output logic               eq,
    output spoc_pkg::entry_t   ent
);

    spoc_pkg::entry_t ent_reg;
    spoc_pkg::entry_t ent_next;
    logic [31:0] kpx, kpy, kex, key;

    always_comb
    begin
        kpx = spoc_pkg::order_key(pt_x);
        kpy = spoc_pkg::order_key(pt_y);
        kex = spoc_pkg::order_key(ent_reg.x);
        key = spoc_pkg::order_key(ent_reg.y);
        eq  = ent_reg.valid && (kpx == kex) && (kpy == key);
        lt  = !ent_reg.valid || (kpx < kex) || ((kpx == kex) && (kpy < key));
    end

    always_comb
    begin
        ent_next = ent_reg;
        if (ctl.pop)
        begin
            ent_next = right;
        end
        else if (ctl.add && ctl.hit)
        begin
            if (eq && (ent_reg.cnt != spoc_pkg::COUNT_MAX))
            begin
                ent_next.cnt = ent_reg.cnt + 32'd1;
            end
        end
        else if (ctl.add && !ctl.full)
        begin
            if (lt_prev)
            begin
                ent_next = left;
            end
            else if (lt)
            begin
                ent_next.valid = 1'b1;
                ent_next.x     = pt_x;
                ent_next.y     = pt_y;
                ent_next.cnt   = 32'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg <= '0;
        end
        else
        begin
            ent_reg <= ent_next;
        end
    end

    assign ent = ent_reg;

endmodule

@@ rtl/sorted_pair_occurrence_counter.sv @@
// ----------------------------------------------------------------------------
// sorted_pair_occurrence_counter
// Counts distinct (x, y) float pairs in a sorted chain of table cells.
// ----------------------------------------------------------------------------
// Input channel s_*: tuser = action (0 add point, 1 finish), tdata = x, y.
// On an add the chain of cells compares the point in parallel and bumps the
// matching count, or inserts it at its sorted slot as the cells above shift
// up by one; a new key on a full table is dropped and sets the overflow flag.
// Sustained rate for adds: one point per cycle.
// A finish switches to emit mode: input ready drops and cell 0 drives the
// output channel m_*, the first result valid in the cycle after the finish;
// each output transaction shifts the chain down by one. The last key is
// marked by tlast. An empty table gives one result with table_empty set.
// When the receiver stalls, the chain holds and the result stays stable.
// After the final result the table is empty and the overflow flag clear.
// Reset clears all valid bits and the overflow flag; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_pair_occurrence_counter (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // x_bits, y_bits
    input  logic         s_tuser,   // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // key_x, key_y, occurrences
    output logic         m_tlast,   // is_last
    output logic [1:0]   m_tuser    // table_empty, overflowed
);

    localparam int D = spoc_pkg::TABLE_DEPTH;

    spoc_pkg::state_t state_reg, state_next;
    logic ovf_reg, ovf_next;
    spoc_pkg::cell_ctl_t ctl;
    spoc_pkg::entry_t ent [D];
    spoc_pkg::entry_t left_in [D];
    spoc_pkg::entry_t right_in [D];
    logic [D-1:0] lt, eq, lt_prev;
    logic s_acc, m_acc;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    genvar g;
    generate
        for (g = 0; g < D; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                assign lt_prev[g] = 1'b0;
                assign left_in[g] = '0;
            end
            else
            begin : g_mid
                assign lt_prev[g] = lt[g-1];
                assign left_in[g] = ent[g-1];
            end
            if (g == D - 1)
            begin : g_last
                assign right_in[g] = '0;
            end
            else
            begin : g_inner
                assign right_in[g] = ent[g+1];
            end
            spoc_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .pt_x    (s_tdata[31:0]),
                .pt_y    (s_tdata[63:32]),
                .lt_prev (lt_prev[g]),
                .left    (left_in[g]),
                .right   (right_in[g]),
                .lt      (lt[g]),
                .eq      (eq[g]),
                .ent     (ent[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        ovf_next   = ovf_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        m_tdata    = {ent[0].cnt, ent[0].y, ent[0].x};
        m_tlast    = !ent[1].valid;
        m_tuser    = {ovf_reg, 1'b0};
        ctl.add    = 1'b0;
        ctl.hit    = |eq;
        ctl.full   = ent[D-1].valid;
        ctl.pop    = 1'b0;
        case (state_reg)
            spoc_pkg::ST_RUN:
            begin
                s_tready = 1'b1;
                if (s_acc)
                begin
                    if (s_tuser)
                    begin
                        state_next = ent[0].valid ? spoc_pkg::ST_EMIT
                                                  : spoc_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        ctl.add = 1'b1;
                        if (!ctl.hit && ctl.full)
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                end
            end
            spoc_pkg::ST_EMIT:
            begin
                m_tvalid = 1'b1;
                if (m_acc)
                begin
                    ctl.pop = 1'b1;
                    if (m_tlast)
                    begin
                        state_next = spoc_pkg::ST_RUN;
                        ovf_next   = 1'b0;
                    end
                end
            end
            spoc_pkg::ST_EMPTY:
            begin
                m_tvalid = 1'b1;
                m_tdata  = '0;
                m_tlast  = 1'b1;
                m_tuser  = {ovf_reg, 1'b1};
                if (m_acc)
                begin
                    state_next = spoc_pkg::ST_RUN;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
                state_next = spoc_pkg::ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spoc_pkg::ST_RUN;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovf_reg   <= ovf_next;
        end
    end

`ifndef SYNTH
    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while emitting");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_acc && m_tlast) |=> (!m_tvalid && !ovf_reg))
        else $error("emit did not end after last");

    a_emit_sorted_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spoc_pkg::ST_EMIT) |-> ent[0].valid)
        else $error("emitting an empty cell");
`endif

endmodule

@@ tb/sv/sorted_pair_occurrence_counter_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_pair_occurrence_counter_tb
// Streams points and finish commands into the sorted pair counter, predicts
// the sorted distinct pairs with their counts, and checks every emitted
// transaction field by field. Covers signed zeros, NaN ordering, full table
// overflow and empty finishes, with random idling.
// ----------------------------------------------------------------------------
module sorted_pair_occurrence_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_FINISH = 1'b1;
    localparam int   LIMIT      = 400000;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] cnt;
        logic        last;
        logic        empty;
        logic        ovf;
    } pair_count_t;

    typedef struct {
        logic        act;
        logic [31:0] x;
        logic [31:0] y;
        logic        has_res;
        pair_count_t res;
    } stim_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic         m_tlast;
    logic [1:0]   m_tuser;

    sorted_pair_occurrence_counter u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    logic [31:0]  tbl_x[spoc_pkg::TABLE_DEPTH];
    logic [31:0]  tbl_y[spoc_pkg::TABLE_DEPTH];
    logic [31:0]  tbl_cnt[spoc_pkg::TABLE_DEPTH];
    int           tbl_used = 0;
    logic         tbl_ovf = 1'b0;
    pair_count_t  pending_pairs[$];
    int           mismatches = 0;
    int           n_results = 0;
    int           n_finish = 0;
    int           n_ovf_runs = 0;
    int           cycles = 0;
    bit           no_stall = 1'b0;
    stim_row_t    rows[$];

    function automatic logic [32:0] float_rank(logic [31:0] b);
        logic [31:0] mag;
        mag = {1'b0, b[30:0]};
        if (b[31])
            return (mag == 0) ? 33'h0_8000_0000 : 33'h0_8000_0000 - mag;
        return 33'h0_8000_0000 + mag;
    endfunction

    // -1, 0, 1 for (ax,ay) vs (bx,by)
    function automatic int pair_order(logic [31:0] ax, logic [31:0] ay,
                                      logic [31:0] bx, logic [31:0] by);
        if (float_rank(ax) != float_rank(bx))
            return float_rank(ax) < float_rank(bx) ? -1 : 1;
        if (float_rank(ay) != float_rank(by))
            return float_rank(ay) < float_rank(by) ? -1 : 1;
        return 0;
    endfunction

    task automatic count_point(logic [31:0] x, logic [31:0] y);
        int pos;
        int c;
        pos = 0;
        while (pos < tbl_used)
        begin
            c = pair_order(x, y, tbl_x[pos], tbl_y[pos]);
            if (c == 0)
            begin
                if (tbl_cnt[pos] != spoc_pkg::COUNT_MAX)
                    tbl_cnt[pos]++;
                return;
            end
            if (c < 0)
                break;
            pos++;
        end
        if (tbl_used >= spoc_pkg::TABLE_DEPTH)
        begin
            tbl_ovf = 1'b1;
            return;
        end
        for (int i = tbl_used; i > pos; i--)
        begin
            tbl_x[i] = tbl_x[i-1];
            tbl_y[i] = tbl_y[i-1];
            tbl_cnt[i] = tbl_cnt[i-1];
        end
        tbl_x[pos] = x;
        tbl_y[pos] = y;
        tbl_cnt[pos] = 32'd1;
        tbl_used++;
    endtask

    task automatic emit_table();
        pair_count_t p;
        n_finish++;
        if (tbl_ovf)
            n_ovf_runs++;
        if (tbl_used == 0)
        begin
            p = '{x: 0, y: 0, cnt: 0, last: 1'b1, empty: 1'b1, ovf: tbl_ovf};
            pending_pairs = {pending_pairs, p};
        end
        for (int k = 0; k < tbl_used; k++)
        begin
            p = '{x: tbl_x[k], y: tbl_y[k], cnt: tbl_cnt[k],
                  last: (k + 1 == tbl_used), empty: 1'b0, ovf: tbl_ovf};
            pending_pairs = {pending_pairs, p};
        end
        tbl_used = 0;
        tbl_ovf = 1'b0;
    endtask

    task automatic gap(int long_pct);
        if ($urandom_range(99) < long_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(40, 10)) @(posedge clk);
        end
        else if ($urandom_range(2) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
    endtask

    // leaves tvalid high so back-to-back transactions need no second assignment
    task automatic send(logic act, logic [31:0] x, logic [31:0] y);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (act == ACT_FINISH)
            emit_table();
        else
            count_point(x, y);
    endtask

    function automatic logic [31:0] rand_float();
        case ($urandom_range(7))
            0: return {1'($urandom_range(1)), 31'd0};
            1: return {1'($urandom_range(1)), 8'hFF, 23'd0};
            2: return {1'($urandom_range(1)), 8'h7F, 23'($urandom_range(3))};
            3: return $urandom();
            default: return {1'($urandom_range(1)), 8'd127 + 8'($urandom_range(3)), 23'd0};
        endcase
    endfunction

    function automatic stim_row_t row(logic act, logic [31:0] x, logic [31:0] y,
                                      logic has_res, pair_count_t r);
        stim_row_t s;
        s.act = act; s.x = x; s.y = y; s.has_res = has_res; s.res = r;
        return s;
    endfunction

    // output side
    always @(posedge clk)
    begin
        pair_count_t got;
        pair_count_t want;
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (m_tvalid && m_tready)
            begin
                got = '{x: m_tdata[31:0], y: m_tdata[63:32], cnt: m_tdata[95:64],
                        last: m_tlast, empty: m_tuser[0], ovf: m_tuser[1]};
                n_results++;
                if (pending_pairs.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", got);
                end
                else
                begin
                    want = pending_pairs.pop_front();
                    if (got.last !== want.last || got.empty !== want.empty ||
                        got.ovf !== want.ovf || got.cnt !== want.cnt ||
                        (!want.empty && (got.x !== want.x || got.y !== want.y)))
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp x=%h y=%h n=%h l%b e%b o%b, ",
                                      "got x=%h y=%h n=%h l%b e%b o%b"},
                                want.x, want.y, want.cnt, want.last, want.empty, want.ovf,
                                got.x, got.y, got.cnt, got.last, got.empty, got.ovf);
                    end
                end
            end
            m_tready <= no_stall ? 1'b1 : ($urandom_range(9) < 7 ? 1'b1
                                          : ($urandom_range(9) == 0 ? 1'b0 : m_tready));
        end
    end

    always @(posedge clk)
    begin
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        pair_count_t none;
        pair_count_t r;
        logic [31:0] px[$];
        logic [31:0] py[$];
        logic [31:0] flip;
        int pick;
        int nsent;
        none = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        r = '{x: 0, y: 0, cnt: 0, last: 1, empty: 1, ovf: 0};
        rows = {rows, row(ACT_FINISH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, r)};
        r = '{x: 32'h8000_0000, y: 32'h0, cnt: 3, last: 1, empty: 0, ovf: 0};
        rows = {rows, row(ACT_ADD, 32'h8000_0000, 32'h0, 1'b0, none)};
        rows = {rows, row(ACT_ADD, 32'h0, 32'h8000_0000, 1'b0, none)};
        rows = {rows, row(ACT_ADD, 32'h0, 32'h0, 1'b0, none)};
        rows = {rows, row(ACT_FINISH, 32'h0, 32'h0, 1'b1, r)};
        rows = {rows, row(ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, none)};
        rows = {rows, row(ACT_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, none)};
        rows = {rows, row(ACT_ADD, 32'hFF80_0000, 32'h7F80_0000, 1'b0, none)};
        rows = {rows, row(ACT_ADD, 32'h7F80_0000, 32'hFF80_0000, 1'b0, none)};
        rows = {rows, row(ACT_ADD, 32'h3F80_0000, 32'hBF80_0000, 1'b0, none)};
        rows = {rows, row(ACT_ADD, 32'h3F80_0000, 32'h3F80_0000, 1'b0, none)};
        rows = {rows, row(ACT_ADD, 32'hFFC0_0000, 32'h0, 1'b0, none)};
        rows = {rows, row(ACT_ADD, 32'h7FC0_0001, 32'h0, 1'b0, none)};
        rows = {rows, row(ACT_ADD, 32'h3F80_0000, 32'hBF80_0000, 1'b0, none)};
        rows = {rows, row(ACT_FINISH, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, none)};

        for (int i = 0; i < rows.size(); i++)
        begin
            int before_n;
            before_n = pending_pairs.size();
            send(rows[i].act, rows[i].x, rows[i].y);
            if (rows[i].has_res && pending_pairs[before_n] !== rows[i].res)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("directed row %0d: predictor disagrees with table", i);
            end
            gap(5);
        end

        // fill past the table depth, then repeat a held key
        for (int i = 0; i < spoc_pkg::TABLE_DEPTH + 3; i++)
            send(ACT_ADD, 32'(i) << 20, 32'h0);
        send(ACT_ADD, 32'h0, 32'h0);
        send(ACT_FINISH, 32'h0, 32'h0);
        // overflow flag on an empty finish cannot happen: flag needs a full table

        nsent = 0;
        while (nsent < 265)
        begin
            int runlen;
            no_stall = ($urandom_range(5) == 0);
            runlen = ($urandom_range(9) == 0) ? $urandom_range(90, 65) : $urandom_range(12);
            px.delete();
            py.delete();
            for (int j = 0; j < runlen; j++)
            begin
                pick = $urandom_range(99);
                if (pick < 40 && px.size() > 0)
                begin
                    pick = $urandom_range(px.size() - 1);
                    // a repeat, sometimes with the other zero sign
                    flip = (px[pick][30:0] == 0) ? {1'($urandom_range(1)), 31'd0} : 32'd0;
                    send(ACT_ADD, px[pick] ^ flip, py[pick]);
                end
                else
                begin
                    px = {px, (runlen > 60) ? $urandom() : rand_float()};
                    py = {py, (runlen > 60) ? $urandom() : rand_float()};
                    send(ACT_ADD, px[$], py[$]);
                end
                nsent++;
                if (!no_stall)
                    gap(3);
            end
            send(ACT_FINISH, $urandom(), $urandom());
            nsent++;
            gap(5);
        end
        s_tvalid <= 1'b0;

        while (pending_pairs.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("%0d finish commands, %0d results, %0d runs with overflow",
                 n_finish, n_results, n_ovf_runs);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

@@ sorted_pair_occurrence_counter.f @@
rtl/spoc_pkg.sv
rtl/spoc_cell.sv
rtl/sorted_pair_occurrence_counter.sv
tb/sv/sorted_pair_occurrence_counter_tb.sv
